@@ rtl/core/tsg_pkg.sv @@
// ----------------------------------------------------------------------------
// tsg_pkg: shared constants and tables of the sine tone generator
// Register indexes, reset values, CORDIC gain and arctangent table.
// ----------------------------------------------------------------------------
package tsg_pkg;

  localparam int RATE_W     = 16;  // sample rate, counters, phase numerator
  localparam int AMP_W      = 15;
  localparam int SAMPLE_W   = 16;
  localparam int TURN_W     = 32;  // CORDIC angle as a fraction of a turn
  localparam int CORDIC_XW  = 34;  // Q2.30 datapath with headroom
  localparam int CORDIC_ZW  = 33;
  localparam int ATAN_IDX_W = 5;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_FREQ   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION    = 2'd3;

  localparam logic [RATE_W-1:0] SAMPLE_RATE_RST = 16'd8000;
  localparam logic [RATE_W-1:0] TONE_FREQ_RST   = 16'd440;
  localparam logic [AMP_W-1:0]  AMPLITUDE_RST   = 15'd32767;
  localparam logic [RATE_W-1:0] DURATION_RST    = 16'd10;

  localparam logic signed [CORDIC_XW-1:0] CORDIC_GAIN = 34'sd652032874;

  // atan(2^-i) as a fraction of a turn, scaled by 2^32
  function automatic logic [TURN_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
    logic [TURN_W-1:0] val;
    case (idx)
      5'd0:  val = 32'h20000000;
      5'd1:  val = 32'h12E4051E;
      5'd2:  val = 32'h09FB385B;
      5'd3:  val = 32'h051111D4;
      5'd4:  val = 32'h028B0D43;
      5'd5:  val = 32'h0145D7E1;
      5'd6:  val = 32'h00A2F61E;
      5'd7:  val = 32'h00517C55;
      5'd8:  val = 32'h0028BE53;
      5'd9:  val = 32'h00145F2F;
      5'd10: val = 32'h000A2F98;
      5'd11: val = 32'h000517CC;
      5'd12: val = 32'h00028BE6;
      5'd13: val = 32'h000145F3;
      5'd14: val = 32'h0000A2FA;
      5'd15: val = 32'h0000517D;
      5'd16: val = 32'h000028BE;
      5'd17: val = 32'h0000145F;
      5'd18: val = 32'h00000A30;
      5'd19: val = 32'h00000518;
      5'd20: val = 32'h0000028C;
      5'd21: val = 32'h00000146;
      5'd22: val = 32'h000000A3;
      5'd23: val = 32'h00000051;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

@@ rtl/core/tsg_divider.sv @@
// ----------------------------------------------------------------------------
// tsg_divider: radix-2 restoring divider
// Shifts QW dividend bits into a running remainder, one bit per cycle.
// The initial remainder must be below the divisor.
// ----------------------------------------------------------------------------
module tsg_divider import tsg_pkg::*; #(
  parameter int QW = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [QW-1:0]     dividend,
  input  logic [RATE_W-1:0] rem_init,
  input  logic [RATE_W-1:0] divisor,
  output logic              done,
  output logic [QW-1:0]     quotient,
  output logic [RATE_W-1:0] remainder
);

  localparam int CW = $clog2(QW);

  logic            busy;
  logic [CW-1:0]   cnt;
  logic [RATE_W:0] trial;
  logic [RATE_W:0] diff;
  logic            fits;

  assign trial = {remainder, quotient[QW-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        cnt       <= '0;
        remainder <= rem_init;
        quotient  <= dividend;
      end else if (busy) begin
        remainder <= fits ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
        quotient  <= {quotient[QW-2:0], fits};
        cnt       <= cnt + 1'b1;
        if (cnt == CW'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/core/tsg_cordic.sv @@
// ----------------------------------------------------------------------------
// tsg_cordic: iterative rotation-mode CORDIC sine
// One micro-rotation per cycle on a quadrant-folded angle; result in Q1.15.
// ----------------------------------------------------------------------------
module tsg_cordic import tsg_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [TURN_W-1:0]          turn,
  output logic                       done,
  output logic signed [SAMPLE_W-1:0] sine
);

  localparam int SW = $clog2(STEPS);

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_FINISH} cstate_t;

  cstate_t                      state;
  logic [SW-1:0]                step;
  logic [1:0]                   quadrant;
  logic signed [CORDIC_XW-1:0]  x;
  logic signed [CORDIC_XW-1:0]  y;
  logic signed [CORDIC_ZW-1:0]  z;
  logic signed [CORDIC_XW-1:0]  dx;
  logic signed [CORDIC_XW-1:0]  dy;
  logic signed [CORDIC_ZW-1:0]  atan_z;
  logic signed [CORDIC_XW-1:0]  v;
  logic signed [CORDIC_XW:0]    v_rnd;
  logic signed [CORDIC_XW-15:0] r;
  logic signed [SAMPLE_W-1:0]   r_sat;

  assign dx     = y >>> step;
  assign dy     = x >>> step;
  assign atan_z = $signed({1'b0, atan_turn(ATAN_IDX_W'(step))});

  always_comb begin
    case (quadrant)
      2'd0:    v = y;
      2'd1:    v = x;
      2'd2:    v = -y;
      default: v = -x;
    endcase
    v_rnd = CORDIC_XW'(v) + (CORDIC_XW+1)'(16384);
    r     = (CORDIC_XW-14)'(v_rnd >>> 15);
    if (r > (CORDIC_XW-14)'(32767)) begin
      r_sat = 16'sh7FFF;
    end else if (r < -(CORDIC_XW-14)'(32768)) begin
      r_sat = 16'sh8000;
    end else begin
      r_sat = r[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
      step  <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          if (start) begin
            quadrant <= turn[TURN_W-1 -: 2];
            x        <= CORDIC_GAIN;
            y        <= '0;
            z        <= CORDIC_ZW'(turn[TURN_W-3:0]);
            step     <= '0;
            state    <= C_RUN;
          end
        end
        C_RUN: begin
          if (z >= 0) begin
            x <= x - dx;
            y <= y + dy;
            z <= z - atan_z;
          end else begin
            x <= x + dx;
            y <= y - dy;
            z <= z + atan_z;
          end
          step <= step + 1'b1;
          if (step == SW'(STEPS - 1)) begin
            state <= C_FINISH;
          end
        end
        C_FINISH: begin
          sine  <= r_sat;
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/sine_tone_generator_top.sv @@
// ----------------------------------------------------------------------------
// sine_tone_generator_top: direct digital synthesis sine tone source
// Turns sample-period ticks into 16-bit sine samples sent as byte pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Tick channel (tick_valid / tick_stall / tick): present one transaction per
//   sample period. A transaction with tick low, or one after the tone has run
//   for duration_seconds, is taken and gives nothing.
//   Data channel (data_valid / data_stall): each active tick yields two
//   transactions, the low byte of the sample (high_half = 0), then the high
//   byte (high_half = 1). final_sample marks both bytes of the last sample.
//   Config port (cfg_write / cfg_index / cfg_data): write sample_rate,
//   tone_frequency, amplitude and duration_seconds while the block is idle.
// Operation:
//   One shared restoring divider does every modulo and the phase division,
//   and an iterative CORDIC does the sine. Each of the count, phase and
//   frequency operands that is not below the sample rate is first reduced
//   by the divider. tick_stall stays high from the accepted tick until the
//   high byte is taken, so no new tick is taken while a sample is in work.
// Reset: registers return to 8000 Hz, 440 Hz, full amplitude, 10 seconds;
//   counters clear. A stalled receiver holds the current byte steady.
// ----------------------------------------------------------------------------
module sine_tone_generator_top import tsg_pkg::*; #(
  parameter int ANGLE_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 tick_valid,
  output logic                 tick_stall,
  input  logic                 tick,
  output logic                 data_valid,
  input  logic                 data_stall,
  output logic [7:0]           data_byte,
  output logic                 high_half,
  output logic                 final_sample,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RATE_W-1:0]    cfg_data
);

  // divider width: enough quotient bits for the angle, enough shifts for a modulo
  localparam int QW = (ANGLE_BITS > RATE_W) ? ANGLE_BITS : RATE_W;

  typedef enum logic [3:0] {
    S_IDLE, S_REDUCE, S_REDUCE_WAIT, S_ANGLE_WAIT, S_ROTATE,
    S_PRODUCT, S_SAMPLE, S_OUT_LO, S_OUT_HI
  } state_t;

  typedef enum logic [1:0] {SEL_COUNT, SEL_PHASE, SEL_FREQ} red_sel_t;

  // configuration registers
  logic [RATE_W-1:0] sample_rate;
  logic [RATE_W-1:0] tone_frequency;
  logic [AMP_W-1:0]  amplitude;
  logic [RATE_W-1:0] duration_seconds;

  // tone state
  logic [RATE_W-1:0] count_in_second;
  logic [RATE_W-1:0] phase_numerator;
  logic [RATE_W-1:0] seconds_done;

  state_t                      state;
  red_sel_t                    red_sel;
  logic [RATE_W-1:0]           count_red;
  logic [RATE_W-1:0]           num_red;
  logic [RATE_W-1:0]           freq_red;
  logic signed [31:0]          product;
  logic [SAMPLE_W-1:0]         sample;
  logic                        last_flag;
  logic                        div_start;
  logic                        cordic_start;

  logic [RATE_W-1:0]           rate;
  logic [RATE_W-1:0]           operand;
  logic [QW-1:0]               div_dividend;
  logic [RATE_W-1:0]           div_rem_init;
  logic                        div_done;
  logic [QW-1:0]               div_quotient;
  logic [RATE_W-1:0]           div_remainder;
  logic [TURN_W-1:0]           turn;
  logic                        cordic_done;
  logic signed [SAMPLE_W-1:0]  sine;
  logic                        wraps;
  logic                        last_next;
  logic [RATE_W:0]             phase_sum;
  logic [RATE_W-1:0]           phase_next;
  logic signed [31:0]          prod_adj;
  logic [SAMPLE_W-1:0]         sample_next;
  logic                        tick_take;
  logic                        data_take;
  logic                        tone_active;

  // ---------------------------------------------------------------------------
  // Configuration writes: no handshake, out-of-range indexes are dropped
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate      <= SAMPLE_RATE_RST;
      tone_frequency   <= TONE_FREQ_RST;
      amplitude        <= AMPLITUDE_RST;
      duration_seconds <= DURATION_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SAMPLE_RATE: sample_rate      <= cfg_data;
        REG_TONE_FREQ:   tone_frequency   <= cfg_data;
        REG_AMPLITUDE:   amplitude        <= cfg_data[AMP_W-1:0];
        REG_DURATION:    duration_seconds <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath helpers
  // ---------------------------------------------------------------------------
  // a zero rate behaves as a rate of one
  assign rate = (sample_rate == '0) ? RATE_W'(1) : sample_rate;

  always_comb begin
    case (red_sel)
      SEL_COUNT: operand = count_in_second;
      SEL_PHASE: operand = phase_numerator;
      SEL_FREQ:  operand = tone_frequency;
      default:   operand = tone_frequency;
    endcase
  end

  // modulo: shift the operand in from zero; angle: start from the numerator and
  // shift in zeros, giving floor(num * 2^QW / rate)
  assign div_dividend = (state == S_ANGLE_WAIT) ? '0 : QW'(operand);
  assign div_rem_init = (state == S_ANGLE_WAIT) ? num_red : '0;

  assign turn = {div_quotient[QW-1 -: ANGLE_BITS], {(TURN_W-ANGLE_BITS){1'b0}}};

  assign wraps     = ({1'b0, count_red} + 1'b1) >= {1'b0, rate};
  assign last_next = wraps && (({1'b0, seconds_done} + 1'b1) >= {1'b0, duration_seconds});

  // both terms are below the rate, so one subtract reduces the sum
  assign phase_sum  = {1'b0, num_red} + {1'b0, freq_red};
  assign phase_next = (phase_sum >= {1'b0, rate}) ? RATE_W'(phase_sum - {1'b0, rate})
                                                  : phase_sum[RATE_W-1:0];

  // divide by 32768 truncating toward zero: bias negative products first
  assign prod_adj    = product[31] ? product + 32'sd32767 : product;
  assign sample_next = SAMPLE_W'(prod_adj >>> 15);

  assign tone_active = seconds_done < duration_seconds;
  assign tick_stall  = (state != S_IDLE);
  assign tick_take   = tick_valid && !tick_stall;
  assign data_valid  = (state == S_OUT_LO) || (state == S_OUT_HI);
  assign data_take   = data_valid && !data_stall;
  assign data_byte   = (state == S_OUT_HI) ? sample[15:8] : sample[7:0];
  assign high_half   = (state == S_OUT_HI);
  assign final_sample = last_flag;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      red_sel         <= SEL_COUNT;
      div_start       <= 1'b0;
      cordic_start    <= 1'b0;
      count_in_second <= '0;
      phase_numerator <= '0;
      seconds_done    <= '0;
      last_flag       <= 1'b0;
    end else begin
      div_start    <= 1'b0;
      cordic_start <= 1'b0;
      case (state)
        S_IDLE: begin
          // drop idle ticks and ticks after the tone has ended
          if (tick_take && tick && tone_active) begin
            red_sel <= SEL_COUNT;
            state   <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          if (operand < rate) begin
            case (red_sel)
              SEL_COUNT: count_red <= operand;
              SEL_PHASE: num_red   <= operand;
              default:   freq_red  <= operand;
            endcase
            if (red_sel == SEL_FREQ) begin
              div_start <= 1'b1;
              state     <= S_ANGLE_WAIT;
            end else begin
              red_sel <= (red_sel == SEL_COUNT) ? SEL_PHASE : SEL_FREQ;
            end
          end else begin
            div_start <= 1'b1;
            state     <= S_REDUCE_WAIT;
          end
        end
        S_REDUCE_WAIT: begin
          if (div_done) begin
            case (red_sel)
              SEL_COUNT: count_red <= div_remainder;
              SEL_PHASE: num_red   <= div_remainder;
              default:   freq_red  <= div_remainder;
            endcase
            if (red_sel == SEL_FREQ) begin
              div_start <= 1'b1;
              state     <= S_ANGLE_WAIT;
            end else begin
              red_sel <= (red_sel == SEL_COUNT) ? SEL_PHASE : SEL_FREQ;
              state   <= S_REDUCE;
            end
          end
        end
        S_ANGLE_WAIT: begin
          if (div_done) begin
            cordic_start <= 1'b1;
            state        <= S_ROTATE;
          end
        end
        S_ROTATE: begin
          if (cordic_done) begin
            state <= S_PRODUCT;
          end
        end
        S_PRODUCT: begin
          product <= $signed({1'b0, amplitude}) * sine;
          state   <= S_SAMPLE;
        end
        S_SAMPLE: begin
          sample    <= sample_next;
          last_flag <= last_next;
          if (wraps) begin
            count_in_second <= '0;
            phase_numerator <= '0;
            seconds_done    <= seconds_done + 1'b1;
          end else begin
            count_in_second <= count_red + 1'b1;
            phase_numerator <= phase_next;
          end
          state <= S_OUT_LO;
        end
        S_OUT_LO: begin
          if (data_take) begin
            state <= S_OUT_HI;
          end
        end
        S_OUT_HI: begin
          if (data_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  tsg_divider #(
    .QW (QW)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .rem_init  (div_rem_init),
    .divisor   (rate),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  tsg_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .turn  (turn),
    .done  (cordic_done),
    .sine  (sine)
  );

endmodule

@@ rtl/core/tsg_checker.sv @@
// ----------------------------------------------------------------------------
// tsg_checker: port-level assertions for the sine tone generator
// Checks byte ordering, busy signaling and output stability over time.
// ----------------------------------------------------------------------------
module tsg_checker (
  input logic       clk,
  input logic       rst,
  input logic       tick_valid,
  input logic       tick_stall,
  input logic       tick,
  input logic       data_valid,
  input logic       data_stall,
  input logic [7:0] data_byte,
  input logic       high_half,
  input logic       final_sample
);

  // hold a stalled byte steady
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    data_valid && data_stall |=> data_valid && $stable(data_byte) &&
      $stable(high_half) && $stable(final_sample))
    else $error("stalled output transaction changed");

  // the high byte follows the low byte, with the same last-sample mark
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    data_valid && !data_stall && !high_half |=> data_valid && high_half &&
      (final_sample == $past(final_sample)))
    else $error("low byte not followed by matching high byte");

  // no new tick while a sample is being delivered
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    data_valid |-> tick_stall)
    else $error("tick accepted while output pending");

  // an idle tick produces nothing
  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    tick_valid && !tick_stall && !tick |=> !data_valid && !tick_stall)
    else $error("idle tick produced activity");

endmodule

bind sine_tone_generator_top tsg_checker u_tsg_checker (.*);

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sine tone generator
// Drives sample ticks and register settings into the block, predicts each
// byte of every sine sample with a bit-exact CORDIC model held in the bench,
// and checks every byte on the data channel against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import tsg_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 6;
  // Worst item: three divider reductions, phase division and CORDIC; the
  // pause below covers a tick that is still being worked on.
  localparam int SETTLE_CYCLES = 120;
  // Longest quiet stretch: settle pause, sender gap, latency, two stalls.
  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_TICKS = 800;
  localparam int PHASE_SHIFT  = 16;
  localparam int STEP_COUNT   = 16;
  localparam longint GAIN_Q30 = 652032874;

  // atan(2^-i) in turns scaled by 2^32
  localparam longint ATAN_TURNS [STEP_COUNT] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
  };

  typedef struct packed {
    logic [7:0] value;
    logic       hi;
    logic       fin;
  } tone_byte_t;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 tick_valid   = 1'b0;
  logic                 tick_stall;
  logic                 tick         = 1'b0;
  logic                 data_valid;
  logic                 data_stall   = 1'b0;
  logic [7:0]           data_byte;
  logic                 high_half;
  logic                 final_sample;
  logic                 cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [RATE_W-1:0]    cfg_data     = '0;

  // Bench copy of the registers and the counters
  logic [15:0] m_rate, m_freq, m_duration;
  logic [14:0] m_amp;
  logic [15:0] m_count, m_phase, m_seconds;

  tone_byte_t bytes_due [$];

  int errors        = 0;
  int bytes_checked = 0;
  int final_bytes   = 0;
  int active_ticks  = 0;
  int ignored_ticks = 0;
  int idle_cycles   = 0;
  bit steady_send   = 1'b0;
  bit steady_drain  = 1'b0;
  int drain_hold    = 0;

  sine_tone_generator_top dut (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .tick         (tick),
    .data_valid   (data_valid),
    .data_stall   (data_stall),
    .data_byte    (data_byte),
    .high_half    (high_half),
    .final_sample (final_sample),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Sine of a 32-bit turn fraction, rounded to Q1.15 and saturated
  function automatic logic signed [15:0] sine_q15(input logic [31:0] turn);
    longint x, y, z, dx, dy, v, r;
    x = GAIN_Q30;
    y = 0;
    z = {34'd0, turn[29:0]};
    for (int i = 0; i < STEP_COUNT; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_TURNS[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_TURNS[i];
      end
    end
    case (turn[31:30])
      2'd0: v = y;
      2'd1: v = x;
      2'd2: v = -y;
      default: v = -x;
    endcase
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic void tone_reset();
    m_rate     = SAMPLE_RATE_RST;
    m_freq     = TONE_FREQ_RST;
    m_amp      = AMPLITUDE_RST;
    m_duration = DURATION_RST;
    m_count    = '0;
    m_phase    = '0;
    m_seconds  = '0;
  endfunction

  function automatic void tone_write(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [15:0] val);
    case (idx)
      REG_SAMPLE_RATE: m_rate     = val;
      REG_TONE_FREQ:   m_freq     = val;
      REG_AMPLITUDE:   m_amp      = val[14:0];
      REG_DURATION:    m_duration = val;
      default: ;
    endcase
  endfunction

  // Advance the bench state by one accepted tick; queue the bytes it yields
  function automatic int tone_advance(input logic tick_bit);
    logic [31:0] rate, count, num, angle;
    logic [47:0] scaled;
    logic [31:0] turn;
    longint      product, smp;
    logic [15:0] smp_bits;
    bit          wraps, last;
    tone_byte_t  b;
    if (!tick_bit) return 0;
    if (m_seconds >= m_duration) return 0;
    rate   = (m_rate == 16'd0) ? 32'd1 : {16'd0, m_rate};
    count  = m_count % rate;
    num    = m_phase % rate;
    scaled = {num[15:0], 32'd0} >> (32 - PHASE_SHIFT);
    angle  = 32'(scaled / rate);
    turn   = {angle[15:0], 16'd0};
    product  = longint'(m_amp) * longint'(sine_q15(turn));
    smp      = product / 32768;
    smp_bits = smp[15:0];
    wraps = (count + 32'd1) >= rate;
    last  = wraps && ({16'd0, m_seconds} + 32'd1 >= {16'd0, m_duration});
    b.value = smp_bits[7:0];
    b.hi    = 1'b0;
    b.fin   = last;
    bytes_due.push_back(b);
    b.value = smp_bits[15:8];
    b.hi    = 1'b1;
    bytes_due.push_back(b);
    if (wraps) begin
      m_count   = '0;
      m_phase   = '0;
      m_seconds = m_seconds + 16'd1;
    end else begin
      m_count = count[15:0] + 16'd1;
      m_phase = 16'((num + ({16'd0, m_freq} % rate)) % rate);
    end
    return 2;
  endfunction

  // Mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Present one tick transaction and wait for it to be taken. Valid is left
  // high on a zero gap so the next call can follow in the same step.
  task automatic send_tick(input logic tick_bit, output int produced);
    int gap;
    tick_valid <= 1'b1;
    tick       <= tick_bit;
    do @(posedge clk); while (tick_stall);
    produced = tone_advance(tick_bit);
    if (produced != 0) active_ticks++;
    else ignored_ticks++;
    gap = steady_send ? 0 : pick_gap();
    if (gap != 0) begin
      tick_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_ticks(input int n);
    int produced;
    repeat (n) send_tick(1'b1, produced);
  endtask

  // Drop valid, drain every predicted byte, then let an in-flight tick finish
  task automatic settle();
    tick_valid <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Hold a write for one edge; the caller lowers the enable
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    tone_write(idx, val);
  endtask

  task automatic program_tone(input logic [15:0] rate, input logic [15:0] freq,
                              input logic [15:0] amp, input logic [15:0] dur);
    write_reg(REG_SAMPLE_RATE, rate);
    write_reg(REG_TONE_FREQ, freq);
    write_reg(REG_AMPLITUDE, amp);
    write_reg(REG_DURATION, dur);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [15:0] dur_after(input int extra);
    int d;
    d = int'(m_seconds) + extra;
    return (d > 65535) ? 16'hFFFF : d[15:0];
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings: 8000 Hz rate, 440 Hz tone, full scale, ten seconds
  task automatic test_reset_defaults();
    int produced;
    send_ticks(3);
    send_tick(1'b0, produced);  // tick low is taken and gives nothing
    send_ticks(1);
    settle();
  endtask

  // Rate of one wraps on every tick, so each sample ends a second; the tone
  // stops after the programmed duration and the next tick is dropped
  task automatic test_tone_end();
    program_tone(16'd1, 16'd3, 16'd32767, dur_after(2));
    send_ticks(3);
    settle();
    // rate zero behaves as a rate of one
    program_tone(16'd0, 16'hFFFF, 16'd12345, dur_after(2));
    send_ticks(2);
    settle();
  endtask

  // Largest rate, frequency at and just below the rate, amplitude extremes
  // and an amplitude write with the unused top bit set
  task automatic test_field_extremes();
    program_tone(16'hFFFF, 16'hFFFF, 16'd32767, 16'hFFFF);
    send_ticks(2);
    settle();
    program_tone(16'hFFFF, 16'hFFFE, 16'hFFFF, 16'hFFFF);
    send_ticks(3);
    settle();
    program_tone(16'hFFFF, 16'h8001, 16'd0, 16'hFFFF);
    send_ticks(2);
    settle();
  endtask

  // Shrink the rate below the running counters so they are reduced first
  task automatic test_rate_shrink();
    program_tone(16'd200, 16'd37, 16'd20000, 16'hFFFF);
    send_ticks(5);
    settle();
    program_tone(16'd3, 16'd7, 16'd20000, 16'hFFFF);
    send_ticks(2);
    settle();
  endtask

  // Duration zero means no output at all
  task automatic test_zero_duration();
    program_tone(16'd50, 16'd5, 16'd30000, 16'd0);
    send_ticks(2);
    settle();
  endtask

  // Random tone settings, each run for a while; short durations reach the
  // last sample and the dropped ticks after it
  task automatic test_random_tones();
    logic [15:0] rate, freq, amp, dur;
    int sel, target, made, dropped, produced;
    while (active_ticks < RANDOM_TICKS) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0: begin
          case ($urandom_range(0, 3))
            0: rate = 16'd0;
            1: rate = 16'd1;
            2: rate = 16'd2;
            default: rate = 16'hFFFF;
          endcase
        end
        1, 2: rate = 16'($urandom_range(65, 65535));
        default: rate = 16'($urandom_range(2, 64));
      endcase
      case ($urandom_range(0, 3))
        0, 1: freq = 16'($urandom_range(0, 65535));
        2: freq = 16'($urandom_range(0, int'(rate) + 5));
        default: freq = ($urandom_range(0, 1) != 0) ? rate : 16'hFFFF;
      endcase
      amp = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) != 0) ? 16'd0 : 16'd32767)
                                        : 16'($urandom_range(0, 65535));
      if (rate <= 16'd64 && $urandom_range(0, 2) != 0) dur = dur_after($urandom_range(0, 3));
      else if ($urandom_range(0, 3) == 0) dur = dur_after(1);
      else dur = 16'hFFFF;
      steady_send = ($urandom_range(0, 3) == 0);
      program_tone(rate, freq, amp, dur);
      target  = $urandom_range(40, 120);
      made    = 0;
      dropped = 0;
      while (made < target && dropped < 3) begin
        if ($urandom_range(0, 11) == 0) begin
          send_tick(1'b0, produced);  // noise transaction
        end else begin
          send_tick(1'b1, produced);
          if (produced != 0) made++;
          else dropped++;
        end
      end
      settle();
    end
    steady_send = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall, and the check of each accepted byte
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    tone_byte_t want;
    int n;
    if (data_valid && !data_stall) begin
      if (bytes_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte: expected none, actual byte=%02h high=%b final=%b",
                 $time, data_byte, high_half, final_sample);
      end else begin
        want = bytes_due.pop_front();
        bytes_checked++;
        if (final_sample) final_bytes++;
        if (data_byte !== want.value) begin
          errors++;
          $display("%0t: data_byte mismatch: expected %02h, actual %02h",
                   $time, want.value, data_byte);
        end
        if (high_half !== want.hi) begin
          errors++;
          $display("%0t: high_half mismatch: expected %b, actual %b",
                   $time, want.hi, high_half);
        end
        if (final_sample !== want.fin) begin
          errors++;
          $display("%0t: final_sample mismatch: expected %b, actual %b",
                   $time, want.fin, final_sample);
        end
      end
    end
    // Flip between stall-free stretches and random back-pressure
    if ($urandom_range(0, 399) == 0) steady_drain = !steady_drain;
    if (drain_hold != 0) begin
      data_stall <= 1'b1;
      drain_hold--;
    end else if (!steady_drain && $urandom_range(0, 3) == 0) begin
      n = pick_gap();
      data_stall <= (n != 0);
      drain_hold = (n != 0) ? n - 1 : 0;
    end else begin
      data_stall <= 1'b0;
    end
  end

  // Watchdog: end the run if nothing moves on any port for too long
  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((tick_valid && !tick_stall) || (data_valid && !data_stall) || cfg_write || rst)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: timeout, %0d bytes still awaited", $time, bytes_due.size());
    $display("== FAIL ==");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    tone_reset();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_tone_end();
    test_field_extremes();
    test_rate_shrink();
    test_zero_duration();
    test_random_tones();

    $display("Covered %0d sounding ticks and %0d dropped or low ticks over many tone settings,",
             active_ticks, ignored_ticks);
    $display("with %0d bytes compared, %0d of them on closing samples.",
             bytes_checked, final_bytes);
    if (errors == 0 && bytes_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
